// ----- hdl/fpa_pkg.sv -----
// Shared types, codes and helpers for the fixed-point ALU.
package fpa_pkg;

  typedef enum logic [3:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_INC      = 4'd4,
    CMD_DEC      = 4'd5,
    CMD_MIN      = 4'd6,
    CMD_MAX      = 4'd7,
    CMD_FROM_INT = 4'd8,
    CMD_TO_INT   = 4'd9
  } fpa_cmd_t;

  localparam int unsigned DIV_STEPS = 33;
  localparam logic [31:0] RAW_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] RAW_MIN   = 32'h8000_0000;

  // Sideband that rides along the divider stages.
  typedef struct packed {
    logic [31:0] res;
    logic        err;
    logic        lt;
    logic        eq;
    logic        gt;
    logic        is_div;
    logic        dz;
    logic        ovf;
    logic        neg;
    logic        aneg;
  } fpa_side_t;

  // Restoring divider state.
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] den;
    logic [32:0] nbits;
    logic [32:0] quo;
  } fpa_div_t;

  // Saturate a 33-bit signed sum: {err, value}.
  function automatic logic [32:0] sat33(input logic [32:0] s);
    logic [32:0] r;
    if (s[32] != s[31]) begin
      r = {1'b1, (s[32] ? RAW_MIN : RAW_MAX)};
    end else begin
      r = {1'b0, s[31:0]};
    end
    return r;
  endfunction

endpackage

// ----- hdl/fixed_point_alu_unit.sv -----
// Pipeline: 2 front stages, 33 divider stages at one quotient bit each,
// and 1 output stage.
// Throughput: one beat per cycle; the whole pipe advances together and
// holds when the output beat is not taken.
// Reset: synchronous active-low rst_n clears all valid bits; data is not reset.
module fixed_point_alu_unit
  import fpa_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // command[3:0], operand_a[35:4], operand_b[67:36], pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // result_value[31:0], less, equal, greater, error, pad
);

  logic        en;
  logic        vld [0:DIV_STEPS];
  fpa_side_t   side [0:DIV_STEPS];
  fpa_div_t    dv [0:DIV_STEPS];
  logic [35:0] odata;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .command   (in_tdata[3:0]),
    .operand_a (in_tdata[35:4]),
    .operand_b (in_tdata[67:36]),
    .s2_valid  (vld[0]),
    .s2_side   (side[0]),
    .s2_div    (dv[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    fpa_div_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .vld_in   (vld[i]),
      .side_in  (side[i]),
      .div_in   (dv[i]),
      .vld_out  (vld[i+1]),
      .side_out (side[i+1]),
      .div_out  (dv[i+1])
    );
  end

  fpa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .vld_in    (vld[DIV_STEPS]),
    .side_in   (side[DIV_STEPS]),
    .div_in    (dv[DIV_STEPS]),
    .out_valid (out_tvalid),
    .out_data  (odata)
  );

  assign out_tdata = {4'd0, odata};

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while output stalled");

  a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot(out_tdata[34:32]))
    else $error("compare flags not one-hot");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(vld[DIV_STEPS]))
    else $error("pipe advanced during stall");

endmodule

// ----- hdl/fpa_front.sv -----
// Decode, simple ops, multiplier and divider setup (two stages).
module fpa_front
  import fpa_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [3:0]  command,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  output logic        s2_valid,
  output fpa_side_t   s2_side,
  output fpa_div_t    s2_div
);

  logic               v1_r;
  fpa_side_t          side1_r, side1_nxt;
  fpa_div_t           div1_r, div1_nxt;
  logic signed [63:0] prod1_r, prod1_nxt;
  logic               v2_r;
  fpa_side_t          side2_r, side2_nxt;
  fpa_div_t           div2_r;

  logic [31:0] a_mag, b_mag;
  logic [64:0] numx;
  logic [32:0] r_add, r_sub, r_inc, r_dec;
  logic [31:0] fi_hi;
  logic        fi_fits;
  logic        lt, gt;

  always_comb begin
    a_mag   = operand_a[31] ? 32'(-operand_a) : operand_a;
    b_mag   = operand_b[31] ? 32'(-operand_b) : operand_b;
    numx    = {33'd0, a_mag} << FRAC_BITS;
    r_add   = sat33({operand_a[31], operand_a} + {operand_b[31], operand_b});
    r_sub   = sat33({operand_a[31], operand_a} - {operand_b[31], operand_b});
    r_inc   = sat33({operand_a[31], operand_a} + 33'd1);
    r_dec   = sat33({operand_a[31], operand_a} - 33'd1);
    fi_hi   = 32'($signed(operand_a) >>> (31 - FRAC_BITS));
    fi_fits = (fi_hi == 32'd0) || (fi_hi == '1);
    lt      = $signed(operand_a) < $signed(operand_b);
    gt      = $signed(operand_a) > $signed(operand_b);

    prod1_nxt = $signed(operand_a) * $signed(operand_b);

    side1_nxt        = '0;
    side1_nxt.lt     = lt;
    side1_nxt.gt     = gt;
    side1_nxt.eq     = (operand_a == operand_b);
    side1_nxt.dz     = (operand_b == 32'd0);
    side1_nxt.ovf    = (numx[64:33] >= b_mag);
    side1_nxt.neg    = operand_a[31] ^ operand_b[31];
    side1_nxt.aneg   = operand_a[31];

    case (command)
      CMD_ADD:      {side1_nxt.err, side1_nxt.res} = r_add;
      CMD_SUB:      {side1_nxt.err, side1_nxt.res} = r_sub;
      CMD_MUL:      side1_nxt.res = '0;
      CMD_DIV:      side1_nxt.is_div = 1'b1;
      CMD_INC:      {side1_nxt.err, side1_nxt.res} = r_inc;
      CMD_DEC:      {side1_nxt.err, side1_nxt.res} = r_dec;
      CMD_MIN:      side1_nxt.res = lt ? operand_a : operand_b;
      CMD_MAX:      side1_nxt.res = gt ? operand_a : operand_b;
      CMD_FROM_INT: begin
        side1_nxt.err = !fi_fits;
        side1_nxt.res = fi_fits ? (operand_a << FRAC_BITS)
                                : (operand_a[31] ? RAW_MIN : RAW_MAX);
      end
      CMD_TO_INT:   side1_nxt.res = 32'($signed(operand_a) >>> FRAC_BITS);
      default: begin
        side1_nxt.res = '0;
        side1_nxt.err = 1'b1;
      end
    endcase

    div1_nxt.rem   = numx[64:33];
    div1_nxt.den   = b_mag;
    div1_nxt.nbits = numx[32:0];
    div1_nxt.quo   = '0;
  end

  // mul flag kept aside: side.res holds nothing useful for mul until stage 2
  logic is_mul1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r   <= side1_nxt;
      div1_r    <= div1_nxt;
      prod1_r   <= prod1_nxt;
      is_mul1_r <= (command == CMD_MUL);
      side2_r   <= side2_nxt;
      div2_r    <= div1_r;
    end
  end

  // stage 2: round-half-away and saturate the product
  logic [63:0] pmag, prnd, pm;

  always_comb begin
    pmag      = prod1_r[63] ? 64'(-prod1_r) : 64'(prod1_r);
    prnd      = pmag + (64'd1 << (FRAC_BITS - 1));
    pm        = prnd >> FRAC_BITS;
    side2_nxt = side1_r;
    if (is_mul1_r) begin
      if (prod1_r[63]) begin
        if (pm > 64'h8000_0000) begin
          side2_nxt.res = RAW_MIN;
          side2_nxt.err = 1'b1;
        end else begin
          side2_nxt.res = 32'(-pm);
        end
      end else begin
        if (pm > 64'h7FFF_FFFF) begin
          side2_nxt.res = RAW_MAX;
          side2_nxt.err = 1'b1;
        end else begin
          side2_nxt.res = pm[31:0];
        end
      end
    end
  end

  assign s2_valid = v2_r;
  assign s2_side  = side2_r;
  assign s2_div   = div2_r;

endmodule

// ----- hdl/fpa_div_step.sv -----
// One quotient bit of the pipelined restoring divider.
module fpa_div_step
  import fpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      vld_in,
  input  fpa_side_t side_in,
  input  fpa_div_t  div_in,
  output logic      vld_out,
  output fpa_side_t side_out,
  output fpa_div_t  div_out
);

  logic      vld_r;
  fpa_side_t side_r;
  fpa_div_t  div_r, div_nxt;
  logic [32:0] t;
  logic        ge;

  always_comb begin
    t       = {div_in.rem, div_in.nbits[32]};
    ge      = (t >= {1'b0, div_in.den});
    div_nxt = div_in;
    div_nxt.rem   = ge ? 32'(t - {1'b0, div_in.den}) : t[31:0];
    div_nxt.nbits = {div_in.nbits[31:0], 1'b0};
    div_nxt.quo   = {div_in.quo[31:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_in;
      div_r  <= div_nxt;
    end
  end

  assign vld_out  = vld_r;
  assign side_out = side_r;
  assign div_out  = div_r;

endmodule

// ----- hdl/fpa_back.sv -----
// Quotient rounding, result select and output register.
module fpa_back
  import fpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld_in,
  input  fpa_side_t   side_in,
  input  fpa_div_t    div_in,
  output logic        out_valid,
  output logic [35:0] out_data
);

  logic        vld_r;
  logic [35:0] data_r, data_nxt;
  logic        rnd;
  logic [33:0] qm;
  logic [31:0] res;
  logic        err;

  always_comb begin
    rnd = ({div_in.rem, 1'b0} >= {1'b0, div_in.den});
    qm  = {1'b0, div_in.quo} + {33'd0, rnd};
    res = side_in.res;
    err = side_in.err;
    if (side_in.is_div) begin
      err = 1'b0;
      if (side_in.dz) begin
        err = 1'b1;
        res = side_in.aneg ? RAW_MIN : RAW_MAX;
      end else if (side_in.neg) begin
        if (side_in.ovf || qm > 34'h0_8000_0000) begin
          err = 1'b1;
          res = RAW_MIN;
        end else begin
          res = 32'(-qm);
        end
      end else begin
        if (side_in.ovf || qm > 34'h0_7FFF_FFFF) begin
          err = 1'b1;
          res = RAW_MAX;
        end else begin
          res = qm[31:0];
        end
      end
    end
    data_nxt = {err, side_in.gt, side_in.eq, side_in.lt, res};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule
